// File: design/pt64_pkg.sv
// Package for primality_test_64: widths, base tier tables, shared types.
// No dependencies.
package pt64_pkg;
  localparam int unsigned W = 64;
  localparam int unsigned NTIER = 8;
  localparam int unsigned NBASE = 12;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    logic start;
    logic sq;
  } mm_req_t;

  function automatic word_t tier_limit(input logic [3:0] t);
    word_t v;
    v = '1;
    case (t)
      4'd0: v = 64'd1373653;
      4'd1: v = 64'd9080191;
      4'd2: v = 64'd4759123141;
      4'd3: v = 64'd1122004669633;
      4'd4: v = 64'd2152302898747;
      4'd5: v = 64'd3474749660383;
      4'd6: v = 64'd341550071728321;
      4'd7: v = 64'd3825123056546413051;
      default: v = '1;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] tier_count(input logic [3:0] t);
    logic [3:0] c;
    case (t)
      4'd0: c = 4'd2;
      4'd1: c = 4'd2;
      4'd2: c = 4'd3;
      4'd3: c = 4'd4;
      4'd4: c = 4'd5;
      4'd5: c = 4'd6;
      4'd6: c = 4'd7;
      4'd7: c = 4'd9;
      default: c = 4'd12;
    endcase
    return c;
  endfunction

  function automatic logic [20:0] full_base(input logic [3:0] i);
    logic [20:0] b;
    case (i)
      4'd0: b = 21'd2;
      4'd1: b = 21'd3;
      4'd2: b = 21'd5;
      4'd3: b = 21'd7;
      4'd4: b = 21'd11;
      4'd5: b = 21'd13;
      4'd6: b = 21'd17;
      4'd7: b = 21'd19;
      4'd8: b = 21'd23;
      4'd9: b = 21'd29;
      4'd10: b = 21'd31;
      default: b = 21'd37;
    endcase
    return b;
  endfunction

  function automatic logic [20:0] tier_base(input logic [3:0] t, input logic [3:0] i);
    logic [20:0] b;
    b = full_base(i);
    case (t)
      4'd0: b = (i == 4'd0) ? 21'd2 : 21'd3;
      4'd1: b = (i == 4'd0) ? 21'd31 : 21'd73;
      4'd2: b = (i == 4'd0) ? 21'd2 : (i == 4'd1) ? 21'd7 : 21'd61;
      4'd3: b = (i == 4'd0) ? 21'd2 : (i == 4'd1) ? 21'd13 :
                (i == 4'd2) ? 21'd23 : 21'd1662803;
      default: b = full_base(i);
    endcase
    return b;
  endfunction
endpackage

// File: design/pt64_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on pt64_pkg.
module pt64_mulmod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pt64_pkg::word_t    a_i,
  input  pt64_pkg::word_t    b_i,
  input  pt64_pkg::word_t    m_i,
  output logic               done_o,
  output pt64_pkg::word_t    p_o
);
  pt64_pkg::word_t acc_q, acc_d, bsh_q, bsh_d, u_q, t;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_d;
  logic [64:0] s1, s2;

  always_comb begin
    s1 = {1'b0, acc_q} + {1'b0, acc_q};
    t = (s1 >= {1'b0, m_i}) ? 64'(s1 - {1'b0, m_i}) : s1[63:0];
    s2 = {1'b0, t} + {1'b0, u_q};
    acc_d = acc_q;
    bsh_d = bsh_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      bsh_d = b_i;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = bsh_q[63] ? ((s2 >= {1'b0, m_i}) ? 64'(s2 - {1'b0, m_i}) : s2[63:0]) : t;
      bsh_d = {bsh_q[62:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_o <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    bsh_q <= bsh_d;
    if (start_i) u_q <= a_i;
  end

  assign p_o = acc_q;
endmodule

// File: design/primality_test_64_top.sv
// Top level of primality_test_64: sequencer around pt64_mulmod.
// Depends on pt64_pkg and pt64_mulmod.
// One candidate at a time. Each modular multiply runs on the bit-serial unit;
// a base costs about (bits of d + popcount of d + r) multiplies, so a 64-bit
// candidate with twelve bases costs the most, small tiers far fewer. Even or
// below-two candidates go straight to the output state without a multiply.
// The result waits in an output register; the next candidate is taken after it.
module primality_test_64_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // candidate[63:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // is_prime[0], zeros[7:1]
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SPLIT = 4'd1, S_TIER = 4'd2, S_BASE = 4'd3,
                         S_PMUL = 4'd4, S_PSQ = 4'd5, S_SQR = 4'd6, S_OUT = 4'd7;

  logic [3:0] st_q;
  pt64_pkg::word_t n_q, d_q, e_q, acc_q, sq_q, x_q;
  logic [5:0] r_q, k_q;
  logic [3:0] tier_q, bi_q, cnt_q;
  logic res_q, ov_q;
  logic mm_start, mm_done;
  pt64_pkg::word_t mm_a, mm_b, mm_p;
  pt64_pkg::mm_req_t req;
  logic [20:0] base;

  assign base = pt64_pkg::tier_base(tier_q, bi_q);
  assign mm_start = req.start;
  assign mm_a = req.sq ? sq_q : (st_q == S_SQR ? x_q : acc_q);
  assign mm_b = req.sq ? sq_q : (st_q == S_SQR ? x_q : sq_q);

  pt64_mulmod u_mm (.clk_i, .rst_ni, .start_i(mm_start), .a_i(mm_a), .b_i(mm_b),
                    .m_i(n_q), .done_o(mm_done), .p_o(mm_p));

  logic go_q;
  always_comb begin
    req.start = go_q;
    req.sq = (st_q == S_PSQ);
  end

  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {7'd0, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      go_q <= 1'b0;
      res_q <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      case (st_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          n_q <= s_axis_tdata;
          d_q <= s_axis_tdata - 64'd1;
          r_q <= '0;
          tier_q <= '0;
          if (s_axis_tdata < 64'd2) begin res_q <= 1'b0; st_q <= S_OUT; end
          else if (s_axis_tdata == 64'd2) begin res_q <= 1'b1; st_q <= S_OUT; end
          else if (!s_axis_tdata[0]) begin res_q <= 1'b0; st_q <= S_OUT; end
          else st_q <= S_SPLIT;
        end
        S_SPLIT: if (!d_q[0]) begin
          d_q <= d_q >> 1;
          r_q <= r_q + 6'd1;
        end else st_q <= S_TIER;
        S_TIER: if (tier_q == 4'd8 || n_q < pt64_pkg::tier_limit(tier_q)) begin
          cnt_q <= pt64_pkg::tier_count(tier_q);
          bi_q <= '0;
          st_q <= S_BASE;
        end else tier_q <= tier_q + 4'd1;
        S_BASE: if (bi_q == cnt_q) begin
          res_q <= 1'b1; st_q <= S_OUT;
        end else if ({43'd0, base} == n_q) begin
          bi_q <= bi_q + 4'd1;
        end else begin
          acc_q <= 64'd1;
          sq_q <= ({43'd0, base} >= n_q) ? {43'd0, base} % 64'd1 + 64'({43'd0, base} - n_q)
                                        : {43'd0, base};
          e_q <= d_q;
          st_q <= S_PMUL;
          go_q <= 1'b1;
        end
        S_PMUL: if (mm_done) begin
          acc_q <= mm_p;
          st_q <= S_PSQ;
          go_q <= 1'b1;
        end
        S_PSQ: if (mm_done) begin
          sq_q <= mm_p;
          e_q <= e_q >> 1;
          if (e_q[63:1] == 63'd0) begin
            x_q <= acc_q; k_q <= '0; st_q <= S_SQR; go_q <= 1'b1;
          end else begin
            st_q <= e_q[1] ? S_PMUL : S_PSQ;
            go_q <= 1'b1;
          end
        end
        S_SQR: if (mm_done) begin
          if (mm_p == 64'd1 && x_q != 64'd1 && x_q != n_q - 64'd1) begin
            res_q <= 1'b0; st_q <= S_OUT;
          end else if (k_q + 6'd1 == r_q) begin
            if (mm_p == 64'd1) begin bi_q <= bi_q + 4'd1; st_q <= S_BASE; end
            else begin res_q <= 1'b0; st_q <= S_OUT; end
          end else begin
            x_q <= mm_p; k_q <= k_q + 6'd1; go_q <= 1'b1;
          end
        end
        S_OUT: if (!ov_q) begin ov_q <= 1'b1; st_q <= S_IDLE; end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !s_axis_tready)
    else $error("accept while busy");
  a_modulus_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_start |-> n_q[0])
    else $error("multiply with even modulus");
endmodule

// File: verif/primality_test_64_top_tb.sv
// Testbench for primality_test_64_top: drives candidates over the input stream and checks
// every is_prime result against a 128-bit arithmetic Miller-Rabin predictor.
// Depends on pt64_pkg (word_t) and the primality_test_64_top RTL.
`timescale 1ns / 100ps

module primality_test_64_top_tb;
  localparam int unsigned CYCLE_LIMIT = 200000000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned N_RANDOM = 345;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // candidate[63:0]
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // is_prime[0], zeros[7:1]

  pt64_pkg::word_t cand_q[$];
  logic        prime_q[$];
  logic        in_fire = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;

  primality_test_64_top uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic pt64_pkg::word_t mul_mod(input pt64_pkg::word_t u,
                                              input pt64_pkg::word_t v,
                                              input pt64_pkg::word_t m);
    logic [127:0] p;
    p = {64'd0, u} * {64'd0, v};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic pt64_pkg::word_t pow_mod(input pt64_pkg::word_t b,
                                              input pt64_pkg::word_t e,
                                              input pt64_pkg::word_t m);
    pt64_pkg::word_t acc, sq;
    acc = 64'd1 % m;
    sq = b % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic witness_ok(input pt64_pkg::word_t n, input pt64_pkg::word_t d,
                                      input int r, input pt64_pkg::word_t a);
    pt64_pkg::word_t x, y;
    if (a == n) return 1'b1;
    x = pow_mod(a, d, n);
    for (int k = 0; k < r; k++) begin
      y = mul_mod(x, x, n);
      if (y == 1 && x != 1 && x != n - 1) return 1'b0;
      x = y;
    end
    return x == 1;
  endfunction

  function automatic logic predict_prime(input pt64_pkg::word_t n);
    pt64_pkg::word_t d;
    int r;
    pt64_pkg::word_t bases[12];
    int cnt;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    d = n - 1;
    r = 0;
    while (!d[0]) begin
      d = d >> 1;
      r++;
    end
    bases = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    cnt = 12;
    if (n < 64'd1373653) begin
      cnt = 2;
    end else if (n < 64'd9080191) begin
      bases[0] = 31; bases[1] = 73; cnt = 2;
    end else if (n < 64'd4759123141) begin
      bases[1] = 7; bases[2] = 61; cnt = 3;
    end else if (n < 64'd1122004669633) begin
      bases[1] = 13; bases[2] = 23; bases[3] = 1662803; cnt = 4;
    end else if (n < 64'd2152302898747) begin
      cnt = 5;
    end else if (n < 64'd3474749660383) begin
      cnt = 6;
    end else if (n < 64'd341550071728321) begin
      cnt = 7;
    end else if (n < 64'd3825123056546413051) begin
      cnt = 9;
    end
    for (int i = 0; i < cnt; i++)
      if (!witness_ok(n, d, r, bases[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic pt64_pkg::word_t random_candidate();
    int unsigned p;
    pt64_pkg::word_t v;
    p = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (p < 25) return v;                                     // any, mostly even/fast
    if (p < 70) return 64'($urandom_range(0, 65535)) | 64'd1;
    if (p < 85) return (v >> $urandom_range(24, 48)) | 64'd1;
    if (p < 95) return (v >> $urandom_range(2, 23)) | 64'd1;
    return v | 64'd1;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      prime_q.push_back(predict_prime(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (prime_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, m_axis_tdata);
        errors <= errors + 1;
      end else begin
        if (m_axis_tdata !== {7'd0, prime_q[0]}) begin
          $display("%0t is_prime mismatch: expected %h, actual %h",
                   $time, {7'd0, prime_q[0]}, m_axis_tdata);
          errors <= errors + 1;
        end
        void'(prime_q.pop_front());
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (in_gap > 0 || cand_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= cand_q.pop_front();
        in_gap <= pick_gap();
      end
    end
  end

  // output backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        m_axis_tready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) out_gap <= pick_gap();
      end
    end
  end

  initial begin
    pt64_pkg::word_t directed[$];
    directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd561, 64'd2047,
                 64'd1373653, 64'd1373651, 64'd9080191, 64'd25326001,
                 64'd3215031751, 64'd4759123141, 64'd1000000007,
                 64'd1122004669633, 64'd2152302898747, 64'd3474749660383,
                 64'd341550071728321, 64'd3825123056546413051,
                 64'h1FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE};
    foreach (directed[i]) cand_q.push_back(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) cand_q.push_back(random_candidate());
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (cand_q.size() == 0 && !s_axis_tvalid && prime_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && prime_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: sim.f
design/pt64_pkg.sv
design/pt64_mulmod.sv
design/primality_test_64_top.sv
verif/primality_test_64_top_tb.sv
